// File: hdl/pspa_pkg.sv
// package for the paged slot pool allocator
// shared types, codes and sizing constants; no dependencies
`default_nettype none

package pspa_pkg;

    localparam int PAGE_LIMIT           = 16;
    localparam int SLOTS_PER_PAGE_LIMIT = 64;
    localparam int SLOT_TOTAL           = PAGE_LIMIT * SLOTS_PER_PAGE_LIMIT;
    localparam int PAGE_W               = $clog2(PAGE_LIMIT);
    localparam int SLOT_W               = $clog2(SLOTS_PER_PAGE_LIMIT);
    localparam int ID_W                 = PAGE_W + SLOT_W;
    localparam int DEPTH_W              = ID_W + 1;
    localparam int STEP_W               = $clog2(SLOT_W);
    localparam int REUSE_W              = 16;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_PAGES     = 2'd1,
        ST_BAD_BOUNDARY = 2'd2,
        ST_MULTI_FREE   = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        CFG_OBJECTS_PER_PAGE  = 3'd0,
        CFG_MAX_PAGES         = 3'd1,
        CFG_HEADER_MODE       = 3'd2,
        CFG_FIRST_DATA_OFFSET = 3'd3,
        CFG_BLOCK_STRIDE      = 3'd4,
        CFG_PAGE_SIZE         = 3'd5
    } cfg_index_t;

    localparam logic [1:0] HDR_BASIC    = 2'd1;
    localparam logic [1:0] HDR_EXTENDED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACHK,
        S_FILL,
        S_POP,
        S_TAKE,
        S_AWR,
        S_FCHK,
        S_DIV,
        S_FREM,
        S_FWR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic         accept;
        logic         fill;
        logic         page_done;
        logic         pop;
        logic         take_id;
        logic         alloc_commit;
        logic         div_init;
        logic         div_step;
        logic         free_rd;
        logic         free_commit;
        logic         set_status;
        status_code_t status_code;
        logic         load_out;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic stack_empty;
        logic page_full;
        logic fill_last;
        logic pre_bad;
        logic div_last;
        logic rem_zero;
        logic slot_used;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: hdl/pspa_ctrl.sv
// controller state machine of the allocator
// depends on pspa_pkg for state, command and status types
`default_nettype none

module pspa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  pspa_pkg::sts_t     sts,
    output pspa_pkg::cmd_t     cmd
);

    pspa_pkg::state_t state_reg;
    pspa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pspa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = pspa_pkg::ST_OK;
        in_stall        = (state_reg != pspa_pkg::S_IDLE);
        case (state_reg)
            pspa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.op ? pspa_pkg::S_FCHK : pspa_pkg::S_ACHK;
                end
            end
            pspa_pkg::S_ACHK:
            begin
                if (!sts.stack_empty)
                begin
                    state_next = pspa_pkg::S_POP;
                end
                else if (sts.page_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pspa_pkg::ST_NO_PAGES;
                    state_next      = pspa_pkg::S_RESULT;
                end
                else
                begin
                    state_next = pspa_pkg::S_FILL;
                end
            end
            pspa_pkg::S_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_last)
                begin
                    cmd.page_done = 1'b1;
                    state_next    = pspa_pkg::S_POP;
                end
            end
            pspa_pkg::S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = pspa_pkg::S_TAKE;
            end
            pspa_pkg::S_TAKE:
            begin
                cmd.take_id = 1'b1;
                state_next  = pspa_pkg::S_AWR;
            end
            pspa_pkg::S_AWR:
            begin
                cmd.alloc_commit = 1'b1;
                state_next       = pspa_pkg::S_RESULT;
            end
            pspa_pkg::S_FCHK:
            begin
                cmd.div_init = 1'b1;
                if (sts.pre_bad)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pspa_pkg::ST_BAD_BOUNDARY;
                    state_next      = pspa_pkg::S_RESULT;
                end
                else
                begin
                    state_next = pspa_pkg::S_DIV;
                end
            end
            pspa_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = pspa_pkg::S_FREM;
                end
            end
            pspa_pkg::S_FREM:
            begin
                if (!sts.rem_zero)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pspa_pkg::ST_BAD_BOUNDARY;
                    state_next      = pspa_pkg::S_RESULT;
                end
                else
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = pspa_pkg::S_FWR;
                end
            end
            pspa_pkg::S_FWR:
            begin
                if (sts.slot_used)
                begin
                    cmd.free_commit = 1'b1;
                end
                else
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pspa_pkg::ST_MULTI_FREE;
                end
                state_next = pspa_pkg::S_RESULT;
            end
            pspa_pkg::S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = pspa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pspa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/pspa_dp.sv
// datapath of the allocator: config, counters, free stack, slot table,
// boundary divider and result register; depends on pspa_pkg
`default_nettype none

module pspa_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [15:0]                  cfg_data,
    input  wire logic                         operation,
    input  wire logic [3:0]                   page_index,
    input  wire logic [15:0]                  byte_offset,
    input  pspa_pkg::cmd_t                    cmd,
    output pspa_pkg::sts_t                    sts,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [1:0]                        status,
    output logic [3:0]                        granted_page,
    output logic [15:0]                       granted_offset,
    output logic [31:0]                       allocation_number,
    output logic [15:0]                       reuse_count,
    output logic [10:0]                       in_use_count,
    output logic [10:0]                       free_count,
    output logic [4:0]                        pages_used,
    output logic [10:0]                       peak_in_use,
    output logic [31:0]                       allocation_total,
    output logic [31:0]                       free_total
);

    localparam int ID_W    = pspa_pkg::ID_W;
    localparam int SLOT_W  = pspa_pkg::SLOT_W;
    localparam int DEPTH_W = pspa_pkg::DEPTH_W;
    localparam int STEP_W  = pspa_pkg::STEP_W;
    localparam int META_W  = pspa_pkg::REUSE_W + 1;

    // configuration
    logic [6:0]  opp_reg;
    logic [4:0]  maxp_reg;
    logic [1:0]  mode_reg;
    logic [11:0] fdo_reg;
    logic [11:0] stride_reg;
    logic [15:0] psize_reg;

    // latched request
    logic [3:0]  pg_reg;
    logic [15:0] off_reg;

    // counters
    logic [DEPTH_W-1:0] depth_reg;
    logic [4:0]         pc_reg;
    logic [10:0]        in_use_reg;
    logic [10:0]        peak_reg;
    logic [31:0]        acnt_reg;
    logic [31:0]        atot_reg;
    logic [31:0]        ftot_reg;
    logic [SLOT_W-1:0]  fill_reg;
    logic [ID_W-1:0]    id_reg;

    // divider
    logic [15:0]        rem_reg;
    logic [SLOT_W-1:0]  q_reg;
    logic [STEP_W-1:0]  step_reg;

    // result being built
    logic [1:0]  st_reg;
    logic [3:0]  gpage_reg;
    logic [15:0] goff_reg;
    logic [31:0] anum_reg;
    logic [15:0] reuse_reg;

    // memories
    logic [ID_W-1:0]   stack_mem [pspa_pkg::SLOT_TOTAL];
    logic [ID_W-1:0]   stack_rd_reg;
    logic [META_W-1:0] meta_mem [pspa_pkg::SLOT_TOTAL];
    logic [META_W-1:0] meta_rd_reg;

    // output register
    logic        ov_reg;
    logic [1:0]  o_status_reg;
    logic [3:0]  o_gpage_reg;
    logic [15:0] o_goff_reg;
    logic [31:0] o_anum_reg;
    logic [15:0] o_reuse_reg;
    logic [10:0] o_inuse_reg;
    logic [10:0] o_free_reg;
    logic [4:0]  o_pages_reg;
    logic [10:0] o_peak_reg;
    logic [31:0] o_atot_reg;
    logic [31:0] o_ftot_reg;

    logic [6:0]         n_eff;
    logic [4:0]         pages_eff;
    logic [11:0]        stride_eff;
    logic [15:0]        diff;
    logic [17:0]        span;
    logic [17:0]        divisor;
    logic               div_ge;
    logic [ID_W-1:0]    fill_id;
    logic               fill_push;
    logic [ID_W-1:0]    rd_id;
    logic               meta_rd_en;
    logic               push_en;
    logic [ID_W-1:0]    push_id;
    logic               meta_wr_en;
    logic [ID_W-1:0]    meta_wr_addr;
    logic [META_W-1:0]  meta_wr_data;
    logic [15:0]        reuse_new;
    logic [17:0]        slot_prod;
    logic [10:0]        inuse_inc;
    logic               hdr_on;

    always_comb
    begin
        if (opp_reg == 7'd0)
            n_eff = 7'd1;
        else if (opp_reg > 7'(pspa_pkg::SLOTS_PER_PAGE_LIMIT))
            n_eff = 7'(pspa_pkg::SLOTS_PER_PAGE_LIMIT);
        else
            n_eff = opp_reg;
        pages_eff  = (maxp_reg > 5'(pspa_pkg::PAGE_LIMIT)) ?
                     5'(pspa_pkg::PAGE_LIMIT) : maxp_reg;
        stride_eff = (stride_reg == 12'd0) ? 12'd1 : stride_reg;
        diff       = off_reg - {4'd0, fdo_reg};
        span       = {stride_eff, 6'd0};
        divisor    = {6'd0, stride_eff} << step_reg;
        div_ge     = ({2'd0, rem_reg} >= divisor);
        fill_id    = {pc_reg[3:0], fill_reg};
        fill_push  = ({1'b0, fill_reg} < n_eff);
        rd_id      = cmd.take_id ? stack_rd_reg : {pg_reg, q_reg};
        meta_rd_en = cmd.take_id || cmd.free_rd;
        hdr_on     = (mode_reg == pspa_pkg::HDR_BASIC) ||
                     (mode_reg == pspa_pkg::HDR_EXTENDED);
        reuse_new  = (mode_reg == pspa_pkg::HDR_EXTENDED) ?
                     meta_rd_reg[15:0] + 16'd1 : meta_rd_reg[15:0];
        slot_prod  = id_reg[SLOT_W-1:0] * stride_reg;
        inuse_inc  = in_use_reg + 11'd1;

        push_en      = (cmd.fill && fill_push) || cmd.free_commit;
        push_id      = cmd.fill ? fill_id : id_reg;
        meta_wr_en   = cmd.fill || cmd.alloc_commit || cmd.free_commit;
        meta_wr_addr = cmd.fill ? fill_id : id_reg;
        meta_wr_data = cmd.alloc_commit ? {1'b1, reuse_new} : '0;
    end

    assign sts.op          = operation;
    assign sts.stack_empty = (depth_reg == '0);
    assign sts.page_full   = (pc_reg >= pages_eff);
    assign sts.fill_last   = (fill_reg == '1);
    assign sts.pre_bad     = ({1'b0, pg_reg} >= pc_reg) || (off_reg >= psize_reg) ||
                             (off_reg < {4'd0, fdo_reg}) || ({2'd0, diff} >= span);
    assign sts.div_last    = (step_reg == '0);
    assign sts.rem_zero    = (rem_reg == 16'd0);
    assign sts.slot_used   = meta_rd_reg[META_W-1];
    assign sts.out_free    = !ov_reg || !out_stall;

    // memories, no reset
    always_ff @(posedge clk)
    begin
        if (push_en && !depth_reg[DEPTH_W-1])
            stack_mem[depth_reg[DEPTH_W-2:0]] <= push_id;
        if (cmd.pop)
            stack_rd_reg <= stack_mem[ID_W'(depth_reg - DEPTH_W'(1))];
        if (meta_wr_en)
            meta_mem[meta_wr_addr] <= meta_wr_data;
        if (meta_rd_en)
            meta_rd_reg <= meta_mem[rd_id];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pg_reg  <= page_index;
            off_reg <= byte_offset;
        end
        if (meta_rd_en)
            id_reg <= rd_id;
        if (cmd.div_init)
        begin
            rem_reg  <= diff;
            q_reg    <= '0;
            step_reg <= STEP_W'(SLOT_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg         <= rem_reg - divisor[15:0];
                q_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.load_out)
        begin
            o_status_reg <= st_reg;
            o_gpage_reg  <= gpage_reg;
            o_goff_reg   <= goff_reg;
            o_anum_reg   <= anum_reg;
            o_reuse_reg  <= reuse_reg;
            o_inuse_reg  <= in_use_reg;
            o_free_reg   <= depth_reg;
            o_pages_reg  <= pc_reg;
            o_peak_reg   <= peak_reg;
            o_atot_reg   <= atot_reg;
            o_ftot_reg   <= ftot_reg;
        end
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opp_reg    <= 7'd4;
            maxp_reg   <= 5'd16;
            mode_reg   <= 2'd1;
            fdo_reg    <= 12'd24;
            stride_reg <= 12'd32;
            psize_reg  <= 16'd152;
            depth_reg  <= '0;
            pc_reg     <= '0;
            in_use_reg <= '0;
            peak_reg   <= '0;
            acnt_reg   <= '0;
            atot_reg   <= '0;
            ftot_reg   <= '0;
            fill_reg   <= '0;
            st_reg     <= '0;
            gpage_reg  <= '0;
            goff_reg   <= '0;
            anum_reg   <= '0;
            reuse_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    pspa_pkg::CFG_OBJECTS_PER_PAGE:  opp_reg    <= cfg_data[6:0];
                    pspa_pkg::CFG_MAX_PAGES:         maxp_reg   <= cfg_data[4:0];
                    pspa_pkg::CFG_HEADER_MODE:       mode_reg   <= cfg_data[1:0];
                    pspa_pkg::CFG_FIRST_DATA_OFFSET: fdo_reg    <= cfg_data[11:0];
                    pspa_pkg::CFG_BLOCK_STRIDE:      stride_reg <= cfg_data[11:0];
                    pspa_pkg::CFG_PAGE_SIZE:         psize_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                st_reg    <= pspa_pkg::ST_OK;
                gpage_reg <= '0;
                goff_reg  <= '0;
                anum_reg  <= '0;
                reuse_reg <= '0;
                if (operation)
                    ftot_reg <= ftot_reg + 32'd1;
            end
            if (cmd.set_status)
                st_reg <= cmd.status_code;
            if (cmd.fill)
                fill_reg <= fill_reg + SLOT_W'(1);
            if (cmd.page_done)
                pc_reg <= pc_reg + 5'd1;
            if (push_en && !depth_reg[DEPTH_W-1])
                depth_reg <= depth_reg + DEPTH_W'(1);
            else if (cmd.pop)
                depth_reg <= depth_reg - DEPTH_W'(1);
            if (cmd.alloc_commit)
            begin
                gpage_reg  <= id_reg[ID_W-1:SLOT_W];
                goff_reg   <= 16'({6'd0, fdo_reg} + slot_prod);
                atot_reg   <= atot_reg + 32'd1;
                in_use_reg <= inuse_inc;
                if (inuse_inc > peak_reg)
                    peak_reg <= inuse_inc;
                if (hdr_on)
                begin
                    acnt_reg <= acnt_reg + 32'd1;
                    anum_reg <= acnt_reg + 32'd1;
                end
                if (mode_reg == pspa_pkg::HDR_EXTENDED)
                    reuse_reg <= reuse_new;
            end
            if (cmd.free_commit && in_use_reg != 11'd0)
                in_use_reg <= in_use_reg - 11'd1;
            if (cmd.load_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid         = ov_reg;
    assign status            = o_status_reg;
    assign granted_page      = o_gpage_reg;
    assign granted_offset    = o_goff_reg;
    assign allocation_number = o_anum_reg;
    assign reuse_count       = o_reuse_reg;
    assign in_use_count      = o_inuse_reg;
    assign free_count        = o_free_reg;
    assign pages_used        = o_pages_reg;
    assign peak_in_use       = o_peak_reg;
    assign allocation_total  = o_atot_reg;
    assign free_total        = o_ftot_reg;

endmodule

`default_nettype wire

// File: hdl/paged_slot_pool_allocator.sv
// top level of the paged slot pool allocator
// joins pspa_ctrl and pspa_dp; depends on pspa_pkg
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------
//  cfg      cfg_write            cfg_index, cfg_data (no read-back)
//  in       in_valid / in_stall  operation, page_index, byte_offset
//  out      out_valid/out_stall  status ... free_total (eleven fields)
//
// one request at a time: an allocate from a non-empty stack runs check, stack
// read, slot table read, commit and result; adding a page first clears all 64
// entries of its slot table row, stacking the configured count. a free runs a
// boundary check, a 6-step quotient search, a remainder check with slot table
// read, commit and result. reset restores config defaults and clears counters;
// the free stack and slot table are not cleared, each page row is cleared when
// the page is added. a transfer in is taken while a result waits on out_stall.
`default_nettype none

module paged_slot_pool_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [3:0]  page_index,
    input  wire logic [15:0] byte_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [3:0]       granted_page,
    output logic [15:0]      granted_offset,
    output logic [31:0]      allocation_number,
    output logic [15:0]      reuse_count,
    output logic [10:0]      in_use_count,
    output logic [10:0]      free_count,
    output logic [4:0]       pages_used,
    output logic [10:0]      peak_in_use,
    output logic [31:0]      allocation_total,
    output logic [31:0]      free_total
);

    // command and status between controller and datapath
    pspa_pkg::cmd_t cmd;
    pspa_pkg::sts_t sts;

    pspa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pspa_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .operation         (operation),
        .page_index        (page_index),
        .byte_offset       (byte_offset),
        .cmd               (cmd),
        .sts               (sts),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .granted_page      (granted_page),
        .granted_offset    (granted_offset),
        .allocation_number (allocation_number),
        .reuse_count       (reuse_count),
        .in_use_count      (in_use_count),
        .free_count        (free_count),
        .pages_used        (pages_used),
        .peak_in_use       (peak_in_use),
        .allocation_total  (allocation_total),
        .free_total        (free_total)
    );

endmodule

`default_nettype wire
